// ===== design/dmt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the longest-match DFA tokenizer.
// No dependencies; used by dmt_ctrl, dmt_datapath and the top level.
package dmt_pkg;

    localparam int NUM_STATES    = 64;
    localparam int PENDING_DEPTH = 32;
    localparam int ALPHABET      = 256;

    localparam int STATE_W = $clog2(NUM_STATES);
    localparam int BYTE_W  = $clog2(ALPHABET);
    localparam int TIDX_W  = STATE_W + BYTE_W;
    localparam int PEND_AW = $clog2(PENDING_DEPTH);
    localparam int PEND_CW = PEND_AW + 1;

    localparam int ACT_W  = 16;
    localparam int LINE_W = 24;
    localparam int COL_W  = 16;
    localparam int OFF_W  = 32;
    localparam int LEN_W  = 6;
    localparam int IDX_W  = 14;

    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 112;

    // request kinds (tuser on the input side)
    localparam logic [1:0] REQ_LOAD_TRANS  = 2'd0;
    localparam logic [1:0] REQ_LOAD_ACTION = 2'd1;
    localparam logic [1:0] REQ_BYTE        = 2'd2;
    localparam logic [1:0] REQ_END         = 2'd3;

    // result kinds (tuser on the output side)
    localparam logic [1:0] RES_TOKEN    = 2'd0;
    localparam logic [1:0] RES_SYNTAX   = 2'd1;
    localparam logic [1:0] RES_END      = 2'd2;
    localparam logic [1:0] RES_OVERFLOW = 2'd3;

    // config register indexes
    localparam logic CFG_START_STATE    = 1'b0;
    localparam logic CFG_DEFAULT_ACTION = 1'b1;

    localparam logic [BYTE_W-1:0] LINE_FEED = 8'h0A;

    typedef struct packed {
        logic       take;      // input word accepted
        logic       rd_start;  // read action of start state
        logic       fresh;     // restart scan in start state
        logic       rd_byte;   // read pending byte at scan position
        logic       rd_trans;  // read transition entry
        logic       rd_next;   // read action of next state
        logic       step;      // advance DFA by one byte
        logic       push;      // capture a result
        logic       cons_rd;   // read byte at buffer head
        logic       cons_upd;  // retire byte at buffer head
        logic       cons_done; // end of consume
        logic       flush;     // send held result as last
        logic [1:0] kind;      // kind of result being pushed
    } t_cmd;

    typedef struct packed {
        logic       full;
        logic       scan_zero;
        logic       scan_lt_count;
        logic       count_zero;
        logic       next_dead;
        logic       no_match;
        logic       cons_zero;
        logic       hold_valid;
        logic       out_free;
    } t_stat;

endpackage

// ===== design/dmt_ctrl.sv =====
`timescale 1ns / 1ps
// Controller for the tokenizer: sequences loads, the scan loop, consume and output.
// Depends on dmt_pkg.
module dmt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [1:0]     i_req_type,
    input  dmt_pkg::t_stat i_stat,
    output logic           o_ready,
    output dmt_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FRESH = 4'd1;
    localparam logic [3:0] ST_STEP  = 4'd2;
    localparam logic [3:0] ST_RDB   = 4'd3;
    localparam logic [3:0] ST_RDT   = 4'd4;
    localparam logic [3:0] ST_RDA   = 4'd5;
    localparam logic [3:0] ST_PUT   = 4'd6;
    localparam logic [3:0] ST_CONS  = 4'd7;
    localparam logic [3:0] ST_CONSB = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_final, n_final;
    logic [1:0] r_kind, n_kind;
    logic [1:0] w_emit_kind;

    assign o_ready     = (r_state == ST_IDLE);
    assign w_emit_kind = i_stat.no_match ? dmt_pkg::RES_SYNTAX : dmt_pkg::RES_TOKEN;

    always_comb begin
        n_state = r_state;
        n_final = r_final;
        n_kind  = r_kind;
        o_cmd   = '0;
        o_cmd.kind = r_kind;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    case (i_req_type)
                        dmt_pkg::REQ_BYTE: begin
                            n_final = 1'b0;
                            if (i_stat.full) begin
                                n_kind  = dmt_pkg::RES_OVERFLOW;
                                n_state = ST_PUT;
                            end else if (i_stat.scan_zero) begin
                                o_cmd.rd_start = 1'b1;
                                n_state = ST_FRESH;
                            end else begin
                                n_state = ST_STEP;
                            end
                        end
                        dmt_pkg::REQ_END: begin
                            n_final = 1'b1;
                            if (i_stat.scan_zero) begin
                                o_cmd.rd_start = 1'b1;
                                n_state = ST_FRESH;
                            end else begin
                                n_state = ST_STEP;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_FRESH: begin
                o_cmd.fresh = 1'b1;
                n_state = ST_STEP;
            end
            ST_STEP: begin
                if (i_stat.scan_lt_count) begin
                    o_cmd.rd_byte = 1'b1;
                    n_state = ST_RDB;
                end else if (!r_final) begin
                    n_state = ST_FIN;
                end else if (i_stat.count_zero) begin
                    n_kind  = dmt_pkg::RES_END;
                    n_state = ST_PUT;
                end else begin
                    n_kind  = w_emit_kind;
                    n_state = ST_PUT;
                end
            end
            ST_RDB: begin
                o_cmd.rd_trans = 1'b1;
                n_state = ST_RDT;
            end
            ST_RDT: begin
                if (i_stat.next_dead) begin
                    n_kind  = w_emit_kind;
                    n_state = ST_PUT;
                end else begin
                    o_cmd.rd_next = 1'b1;
                    n_state = ST_RDA;
                end
            end
            ST_RDA: begin
                o_cmd.step = 1'b1;
                n_state = ST_STEP;
            end
            ST_PUT: begin
                if (!i_stat.hold_valid || i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    if (r_kind == dmt_pkg::RES_TOKEN || r_kind == dmt_pkg::RES_SYNTAX) begin
                        n_state = ST_CONS;
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_CONS: begin
                if (i_stat.cons_zero) begin
                    o_cmd.cons_done = 1'b1;
                    o_cmd.rd_start  = 1'b1;
                    n_state = ST_FRESH;
                end else begin
                    o_cmd.cons_rd = 1'b1;
                    n_state = ST_CONSB;
                end
            end
            ST_CONSB: begin
                o_cmd.cons_upd = 1'b1;
                n_state = ST_CONS;
            end
            ST_FIN: begin
                if (!i_stat.hold_valid) begin
                    n_state = ST_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_final <= 1'b0;
            r_kind  <= dmt_pkg::RES_TOKEN;
        end else begin
            r_state <= n_state;
            r_final <= n_final;
            r_kind  <= n_kind;
        end
    end

endmodule

// ===== design/dmt_datapath.sv =====
`timescale 1ns / 1ps
// Datapath for the tokenizer: tables, pending byte ring, scan and position registers,
// result hold and output registers. Depends on dmt_pkg.
module dmt_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dmt_pkg::t_cmd                 i_cmd,
    input  logic [1:0]                    i_req_type,
    input  logic [dmt_pkg::S_DATA_W-1:0]  i_data,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [dmt_pkg::ACT_W-1:0]     i_cfg_data,
    input  logic                          i_m_tready,
    output dmt_pkg::t_stat                o_stat,
    output logic                          o_m_tvalid,
    output logic [dmt_pkg::M_DATA_W-1:0]  o_m_tdata,
    output logic [1:0]                    o_m_tuser,
    output logic                          o_m_tlast
);

    localparam int SW = dmt_pkg::STATE_W;
    localparam int AW = dmt_pkg::PEND_AW;
    localparam int CW = dmt_pkg::PEND_CW;
    localparam int RW = 2 * dmt_pkg::ACT_W;
    localparam int FW = dmt_pkg::M_DATA_W;

    // input word fields
    logic [dmt_pkg::IDX_W-1:0]  w_index;
    logic [SW-1:0]              w_next;
    logic [dmt_pkg::ACT_W-1:0]  w_act, w_var;
    logic [dmt_pkg::BYTE_W-1:0] w_byte;
    assign w_index = i_data[13:0];
    assign w_next  = i_data[19:14];
    assign w_act   = i_data[35:20];
    assign w_var   = i_data[51:36];
    assign w_byte  = i_data[59:52];

    logic [SW-1:0]                 tmem [dmt_pkg::NUM_STATES*dmt_pkg::ALPHABET];
    logic [RW-1:0]                 amem [dmt_pkg::NUM_STATES];
    logic [dmt_pkg::BYTE_W-1:0]    pmem [dmt_pkg::PENDING_DEPTH];

    logic [SW-1:0]                 r_tq;
    logic [RW-1:0]                 r_aq;
    logic [dmt_pkg::BYTE_W-1:0]    r_pq;

    logic [SW-1:0]                 r_start;
    logic [dmt_pkg::ACT_W-1:0]     r_default;
    logic [AW-1:0]                 r_head;
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 r_scan;
    logic [SW-1:0]                 r_dfa;
    logic [RW-1:0]                 r_best;
    logic [dmt_pkg::LEN_W-1:0]     r_best_len;
    logic [dmt_pkg::LINE_W-1:0]    r_line;
    logic [dmt_pkg::COL_W-1:0]     r_col;
    logic [dmt_pkg::OFF_W-1:0]     r_off;
    logic [dmt_pkg::LEN_W-1:0]     r_cons_left;

    logic                          r_hold_valid;
    logic [FW-1:0]                 r_hold_data;
    logic [1:0]                    r_hold_kind;
    logic                          r_out_valid;
    logic [FW-1:0]                 r_out_data;
    logic [1:0]                    r_out_kind;
    logic                          r_out_last;

    logic                          w_take_load_t, w_take_load_a, w_take_byte;
    logic [AW-1:0]                 w_rd_addr;
    logic [SW-1:0]                 w_ard_addr;
    logic                          w_out_free;
    logic [FW-1:0]                 w_new_data;
    logic                          w_is_token;

    assign w_take_load_t = i_cmd.take && (i_req_type == dmt_pkg::REQ_LOAD_TRANS);
    assign w_take_load_a = i_cmd.take && (i_req_type == dmt_pkg::REQ_LOAD_ACTION)
                           && (w_index[dmt_pkg::IDX_W-1:SW] == '0);
    assign w_take_byte   = i_cmd.take && (i_req_type == dmt_pkg::REQ_BYTE) && !r_count[AW];

    assign w_rd_addr  = i_cmd.cons_rd ? r_head : r_head + r_scan[AW-1:0];
    assign w_ard_addr = i_cmd.rd_start ? r_start : r_tq;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_is_token = (i_cmd.kind == dmt_pkg::RES_TOKEN);

    // result fields from low bits: action, variant, length, line, column, offset
    assign w_new_data = {r_off, r_col, r_line,
                         w_is_token ? r_best_len :
                         (i_cmd.kind == dmt_pkg::RES_SYNTAX) ? dmt_pkg::LEN_W'(1)
                                                             : dmt_pkg::LEN_W'(0),
                         w_is_token ? r_best : RW'(0)};

    assign o_stat.full          = r_count[AW];
    assign o_stat.scan_zero     = (r_scan == '0);
    assign o_stat.scan_lt_count = (r_scan < r_count);
    assign o_stat.count_zero    = (r_count == '0);
    assign o_stat.next_dead     = (r_tq == '0);
    assign o_stat.no_match      = (r_best[dmt_pkg::ACT_W-1:0] == r_default)
                                  || (r_best_len == '0);
    assign o_stat.cons_zero     = (r_cons_left == '0);
    assign o_stat.hold_valid    = r_hold_valid;
    assign o_stat.out_free      = w_out_free;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

    // table memories
    always_ff @(posedge i_clk) begin
        if (w_take_load_t) begin
            tmem[w_index[dmt_pkg::TIDX_W-1:0]] <= w_next;
        end
        if (i_cmd.rd_trans) begin
            r_tq <= tmem[{r_dfa, r_pq}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_load_a) begin
            amem[w_index[SW-1:0]] <= {w_var, w_act};
        end
        if (i_cmd.rd_start || i_cmd.rd_next) begin
            r_aq <= amem[w_ard_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_byte) begin
            pmem[r_head + r_count[AW-1:0]] <= w_byte;
        end
        if (i_cmd.rd_byte || i_cmd.cons_rd) begin
            r_pq <= pmem[w_rd_addr];
        end
    end

    // scan and position state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= SW'(1);
            r_default   <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_scan      <= '0;
            r_best_len  <= '0;
            r_line      <= dmt_pkg::LINE_W'(1);
            r_col       <= dmt_pkg::COL_W'(1);
            r_off       <= '0;
            r_cons_left <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == dmt_pkg::CFG_START_STATE) begin
                    r_start <= i_cfg_data[SW-1:0];
                end else begin
                    r_default <= i_cfg_data;
                end
            end
            if (w_take_byte) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.fresh) begin
                r_dfa      <= r_start;
                r_best     <= r_aq;
                r_best_len <= '0;
            end
            if (i_cmd.step) begin
                r_dfa <= r_tq;
                if (r_aq[dmt_pkg::ACT_W-1:0] != r_default) begin
                    r_best     <= r_aq;
                    r_best_len <= dmt_pkg::LEN_W'(r_scan) + dmt_pkg::LEN_W'(1);
                end
                r_scan <= r_scan + CW'(1);
            end
            if (i_cmd.push) begin
                r_cons_left <= w_is_token ? r_best_len : dmt_pkg::LEN_W'(1);
            end
            if (i_cmd.cons_upd) begin
                r_cons_left <= r_cons_left - dmt_pkg::LEN_W'(1);
                r_head      <= r_head + AW'(1);
                r_count     <= r_count - CW'(1);
                if (r_off != '1) begin
                    r_off <= r_off + dmt_pkg::OFF_W'(1);
                end
                if (r_pq == dmt_pkg::LINE_FEED) begin
                    if (r_line != '1) begin
                        r_line <= r_line + dmt_pkg::LINE_W'(1);
                    end
                    r_col <= dmt_pkg::COL_W'(1);
                end else if (r_col != '1) begin
                    r_col <= r_col + dmt_pkg::COL_W'(1);
                end
            end
            if (i_cmd.cons_done) begin
                r_scan     <= '0;
                r_best_len <= '0;
            end
        end
    end

    // one held result so the final one can be tagged last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_hold_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_hold_valid <= 1'b0;
            end
            if ((i_cmd.push && r_hold_valid) || i_cmd.flush) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_hold_data <= w_new_data;
            r_hold_kind <= i_cmd.kind;
        end
        if ((i_cmd.push && r_hold_valid) || i_cmd.flush) begin
            r_out_data <= r_hold_data;
            r_out_kind <= r_hold_kind;
            r_out_last <= i_cmd.flush;
        end
    end

endmodule

// ===== design/dfa_maximal_munch_tokenizer.sv =====
`timescale 1ns / 1ps
// Top level of the longest-match DFA tokenizer: joins controller and datapath.
// Depends on dmt_pkg, dmt_ctrl and dmt_datapath.
//
// Input stream (s_axis): tuser selects the word kind: load transition entry,
// load action entry, text byte or end of input. Loads give no result.
// A text byte is buffered (up to 32 pending) and scanned. Each scanned
// byte reads the pending buffer, transition table and action table in
// turn; a token emission retires each consumed byte, after which leftover
// bytes are rescanned. The input stays not ready until an accepted
// byte is scanned and its results are emitted, one byte at a time.
// Output stream (m_axis): one word per result, tlast on the final result
// of an input word. One result is held back until the next one or the end
// of the item is known, so tlast is exact; a stalled receiver stalls the
// scan but a finished result waits in the output register.
// Configuration: i_cfg_we writes start state (index 0) or default action
// (index 1); the user must do so only while idle (not enforced). Reset
// (sync, i_rst_n low) clears buffer and positions; tables undefined till loaded.
module dfa_maximal_munch_tokenizer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [dmt_pkg::ACT_W-1:0]     i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // table_index, next_state, action_code, variant_code, data_byte, zero pad
    input  logic [dmt_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // token_action, token_variant, token_length, start_line, start_column,
    // start_offset, zero pad
    output logic [dmt_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // result_kind
    output logic [1:0]                    m_axis_tuser,
    output logic                          m_axis_tlast
);

    dmt_pkg::t_cmd  w_cmd;
    dmt_pkg::t_stat w_stat;

    dmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .i_req_type (s_axis_tuser),
        .i_stat     (w_stat),
        .o_ready    (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    dmt_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_req_type (s_axis_tuser),
        .i_data     (s_axis_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_m_tready (m_axis_tready),
        .o_stat     (w_stat),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser),
        .o_m_tlast  (m_axis_tlast)
    );

endmodule

// ===== tb/sv/tb_dfa_maximal_munch_tokenizer.sv =====
`timescale 1ns / 1ps
// Testbench for dfa_maximal_munch_tokenizer: table loads, directed scans, then random text.
// Results are predicted by a longest-match scanner in this file. Depends on dmt_pkg.
module tb_dfa_maximal_munch_tokenizer;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 400;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] act;
        logic [15:0] vrnt;
        logic [5:0]  len;
        logic [23:0] line;
        logic [15:0] col;
        logic [31:0] off;
        logic        last;
    } t_tok;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic                           i_cfg_idx;
    logic [dmt_pkg::ACT_W-1:0]      i_cfg_data;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [dmt_pkg::S_DATA_W-1:0]   s_axis_tdata;
    logic [1:0]                     s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [dmt_pkg::M_DATA_W-1:0]   m_axis_tdata;
    logic [1:0]                     m_axis_tuser;
    logic                           m_axis_tlast;

    dfa_maximal_munch_tokenizer dut (.*);

    // scanner shadow state
    logic [5:0]  trans_mem [dmt_pkg::NUM_STATES*dmt_pkg::ALPHABET];
    logic [31:0] act_mem [dmt_pkg::NUM_STATES];
    logic [7:0]  pend_q [$];
    int          scan_pos;
    logic [5:0]  dfa_st;
    logic [31:0] best_av;
    int          best_len;
    logic [23:0] cur_line;
    logic [15:0] cur_col;
    logic [31:0] cur_off;
    logic [5:0]  start_st;
    logic [15:0] dflt_act;

    t_tok tok_q [$];
    int   errors;
    int   cyc;
    int   burst_left;
    int   rmode;
    logic [5:0] live_states [8] = '{6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd63};
    logic [15:0] act_pool [4] = '{16'h0000, 16'h0001, 16'h1234, 16'hFFFF};
    // text uses only these bytes, so only their table columns are loaded
    logic [7:0] byte_pool [5] = '{8'h00, 8'h41, dmt_pkg::LINE_FEED, 8'h7A, 8'hFF};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void push_tok(logic [1:0] kind, logic [15:0] a, logic [15:0] v,
                                     logic [5:0] len);
        t_tok t;
        t = '{kind, a, v, len, cur_line, cur_col, cur_off, 1'b0};
        tok_q.push_back(t);
    endfunction

    function automatic void retire(int n);
        for (int i = 0; i < n && pend_q.size() > 0; i++) begin
            if (cur_off != 32'hFFFF_FFFF) cur_off++;
            if (pend_q[0] == dmt_pkg::LINE_FEED) begin
                if (cur_line != 24'hFF_FFFF) cur_line++;
                cur_col = 16'd1;
            end else if (cur_col != 16'hFFFF) begin
                cur_col++;
            end
            void'(pend_q.pop_front());
        end
        scan_pos = 0;
        best_len = 0;
    endfunction

    function automatic void emit_match();
        if (best_av[15:0] == dflt_act || best_len == 0) begin
            push_tok(dmt_pkg::RES_SYNTAX, 16'h0, 16'h0, 6'd1);
            retire(1);
        end else begin
            push_tok(dmt_pkg::RES_TOKEN, best_av[15:0], best_av[31:16], best_len[5:0]);
            retire(best_len);
        end
    endfunction

    function automatic void munch(bit at_end);
        logic [5:0]  ns;
        logic [31:0] a;
        forever begin
            if (scan_pos == 0) begin
                dfa_st   = start_st;
                best_av  = act_mem[start_st];
                best_len = 0;
            end
            if (scan_pos < pend_q.size()) begin
                ns = trans_mem[{dfa_st, pend_q[scan_pos]}];
                if (ns != 0) begin
                    a = act_mem[ns];
                    dfa_st = ns;
                    if (a[15:0] != dflt_act) begin
                        best_av  = a;
                        best_len = scan_pos + 1;
                    end
                    scan_pos++;
                end else begin
                    emit_match();
                end
            end else begin
                if (!at_end) break;
                if (pend_q.size() == 0) begin
                    push_tok(dmt_pkg::RES_END, 16'h0, 16'h0, 6'd0);
                    break;
                end
                emit_match();
            end
        end
    endfunction

    function automatic void predict_word(logic [1:0] req, logic [13:0] idx, logic [5:0] nxt,
                                         logic [15:0] a, logic [15:0] v, logic [7:0] b);
        int n0;
        n0 = tok_q.size();
        case (req)
            dmt_pkg::REQ_LOAD_TRANS:  trans_mem[idx] = nxt;
            dmt_pkg::REQ_LOAD_ACTION: if (idx < dmt_pkg::NUM_STATES) act_mem[idx] = {v, a};
            dmt_pkg::REQ_BYTE: begin
                if (pend_q.size() >= dmt_pkg::PENDING_DEPTH) begin
                    push_tok(dmt_pkg::RES_OVERFLOW, 16'h0, 16'h0, 6'd0);
                end else begin
                    pend_q.push_back(b);
                    munch(1'b0);
                end
            end
            default: munch(1'b1);
        endcase
        if (tok_q.size() > n0) tok_q[$].last = 1'b1;
    endfunction

    task automatic send_word(logic [1:0] req, logic [13:0] idx, logic [5:0] nxt,
                             logic [15:0] a, logic [15:0] v, logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {4'h0, b, v, a, nxt, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_word(req, idx, nxt, a, v, b);
    endtask

    function automatic logic [7:0] pick_byte();
        return byte_pool[$urandom_range(4)];
    endfunction

    task automatic send_byte(logic [7:0] b);
        send_word(dmt_pkg::REQ_BYTE, 14'($urandom), 6'($urandom), 16'($urandom),
                  16'($urandom), b);
    endtask

    task automatic send_end();
        send_word(dmt_pkg::REQ_END, 14'($urandom), 6'($urandom), 16'($urandom),
                  16'($urandom), 8'($urandom));
    endtask

    task automatic load_trans(logic [5:0] st, logic [7:0] b, logic [5:0] nxt);
        send_word(dmt_pkg::REQ_LOAD_TRANS, {st, b}, nxt, 16'($urandom), 16'($urandom),
                  8'($urandom));
    endtask

    task automatic load_action(logic [13:0] idx, logic [15:0] a, logic [15:0] v);
        send_word(dmt_pkg::REQ_LOAD_ACTION, idx, 6'($urandom), a, v, 8'($urandom));
    endtask

    function automatic logic [5:0] pick_target();
        return ($urandom_range(99) < 35) ? 6'd0 : live_states[$urandom_range(7)];
    endfunction

    task automatic load_row(logic [5:0] st);
        foreach (byte_pool[i]) load_trans(st, byte_pool[i], pick_target());
    endtask

    // drains every pending result, then lets a possible silent rescan finish
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (tok_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [15:0] val);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == dmt_pkg::CFG_START_STATE) start_st = val[5:0];
        else dflt_act = val;
    endtask

    task automatic test_table_load();
        foreach (live_states[i])
            load_action(14'(live_states[i]), act_pool[$urandom_range(3)], 16'($urandom));
        load_action(14'd1, 16'hFFFF, 16'hFFFF);
        load_action(14'd2, 16'h0000, 16'h0000);
        // indexes past the action table are ignored
        load_action(14'd64, 16'h5555, 16'hAAAA);
        load_action(14'h3FFF, 16'hAAAA, 16'h5555);
        foreach (live_states[i]) load_row(live_states[i]);
        load_trans(6'd63, 8'hFF, 6'd63);
    endtask

    task automatic test_basic_text();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h41);
        send_byte(dmt_pkg::LINE_FEED);
        send_byte(8'h7A);
        send_byte(dmt_pkg::LINE_FEED);
        send_end();
        send_end();
    endtask

    task automatic test_config_extremes();
        write_cfg(dmt_pkg::CFG_DEFAULT_ACTION, 16'hFFFF);
        write_cfg(dmt_pkg::CFG_START_STATE, 16'd63);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_end();
    endtask

    // accepting start state, dead on first byte: one-byte syntax error
    task automatic test_empty_match();
        write_cfg(dmt_pkg::CFG_DEFAULT_ACTION, 16'h0000);
        load_action(14'd63, 16'hABCD, 16'h0001);
        load_trans(6'd63, 8'h41, 6'd0);
        send_byte(8'h41);
        send_byte(8'h41);
        send_end();
    endtask

    // never-dying loop fills the buffer, next bytes are dropped, end flushes all
    task automatic test_overflow();
        foreach (byte_pool[i]) begin
            load_trans(6'd6, byte_pool[i], 6'd7);
            load_trans(6'd7, byte_pool[i], 6'd7);
        end
        load_action(14'd6, 16'h0001, 16'h0006);
        load_action(14'd7, 16'h0000, 16'h0007);
        write_cfg(dmt_pkg::CFG_START_STATE, 16'd6);
        for (int i = 0; i < dmt_pkg::PENDING_DEPTH + 2; i++)
            send_byte((i % 5 == 0) ? dmt_pkg::LINE_FEED : pick_byte());
        send_end();
        wait_idle();
        load_row(6'd6);
        load_row(6'd7);
        load_action(14'd6, act_pool[$urandom_range(3)], 16'($urandom));
        load_action(14'd7, act_pool[$urandom_range(3)], 16'($urandom));
    endtask

    task automatic test_random_text();
        int r;
        logic [13:0] idx;
        logic [5:0]  st;
        for (int ph = 0; ph < 4; ph++) begin
            write_cfg(dmt_pkg::CFG_START_STATE,
                      (ph == 0) ? 16'd1 : 16'(live_states[$urandom_range(7)]));
            write_cfg(dmt_pkg::CFG_DEFAULT_ACTION, act_pool[$urandom_range(3)]);
            for (int n = 0; n < 10; n++) begin
                r = $urandom_range(99);
                if (r < 5) begin
                    send_end();
                end else if (r < 10) begin
                    st = 6'($urandom);
                    if (st inside {live_states})
                        load_trans(st, pick_byte(), pick_target());
                    else
                        load_trans(st, pick_byte(), 6'($urandom));
                end else if (r < 13) begin
                    idx = ($urandom_range(3) == 0) ? 14'($urandom) : 14'($urandom_range(63));
                    load_action(idx, act_pool[$urandom_range(3)], 16'($urandom));
                end else begin
                    send_byte(($urandom_range(4) == 0) ? dmt_pkg::LINE_FEED : pick_byte());
                end
            end
            send_end();
        end
    endtask

    // receiver: free-running, coin-flip or mostly stalled, switching mode now and then
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc % 97 == 0) rmode <= $urandom_range(2);
        m_axis_tready <= (rmode == 0) ? 1'b1 :
                         (rmode == 1) ? 1'($urandom_range(1)) : ($urandom_range(7) == 0);
        if (cyc > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            $display("%0t: %s expected %0h got %0h", $time, name, e, a);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_tok e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (tok_q.size() == 0) begin
                $display("%0t: unexpected word kind %0d expected none got %0h", $time,
                         m_axis_tuser, m_axis_tdata);
                errors++;
            end else begin
                e = tok_q.pop_front();
                check_field("kind", 32'(e.kind), 32'(m_axis_tuser));
                check_field("action", 32'(e.act), 32'(m_axis_tdata[15:0]));
                check_field("variant", 32'(e.vrnt), 32'(m_axis_tdata[31:16]));
                check_field("length", 32'(e.len), 32'(m_axis_tdata[37:32]));
                check_field("line", 32'(e.line), 32'(m_axis_tdata[61:38]));
                check_field("column", 32'(e.col), 32'(m_axis_tdata[77:62]));
                check_field("offset", e.off, m_axis_tdata[109:78]);
                check_field("last", 32'(e.last), 32'(m_axis_tlast));
            end
        end
    end

    initial begin
        errors     = 0;
        cyc        = 0;
        rmode      = 0;
        burst_left = 0;
        scan_pos   = 0;
        best_len   = 0;
        cur_line   = 24'd1;
        cur_col    = 16'd1;
        cur_off    = 32'd0;
        start_st   = 6'd1;
        dflt_act   = 16'h0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= dmt_pkg::CFG_START_STATE;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= dmt_pkg::REQ_BYTE;
        m_axis_tready <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_load();
        test_basic_text();
        test_config_extremes();
        test_empty_match();
        test_overflow();
        test_random_text();

        wait_idle();
        if (errors == 0 && tok_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/dmt_pkg.sv
design/dmt_ctrl.sv
design/dmt_datapath.sv
design/dfa_maximal_munch_tokenizer.sv
tb/sv/tb_dfa_maximal_munch_tokenizer.sv
